// File: hdl/lds_pkg.sv
// Package for the LED driver serial command shifter.
// Command codes, register indexes, fixed run lengths and width helpers.
// No dependencies.
package lds_pkg;

	localparam int WORD_BITS_DEF  = 16;
	localparam int MAX_IDLE_DEF   = 64;

	localparam int WORD_FIELD_W   = 16;
	localparam int IDLE_FIELD_W   = 7;
	localparam int KIND_W         = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 7;

	localparam int PREACT_CLOCKS  = 14;
	localparam int VSYNC_CLOCKS   = 2;
	localparam int SRESET_CLOCKS  = 10;
	localparam int CFG_LATCH_BITS = 4;

	localparam int QUEUE_DEPTH    = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_DATA   = 3'd0,
		KIND_CONFIG = 3'd1,
		KIND_PREACT = 3'd2,
		KIND_VSYNC  = 3'd3,
		KIND_SRESET = 3'd4,
		KIND_IDLE   = 3'd5
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GHOST     = 3'd0,
		REG_SCAN      = 3'd1,
		REG_GRAY      = 3'd2,
		REG_GCLK      = 3'd3,
		REG_CURRENT   = 3'd4
	} cfg_reg_t;

	// Counter width that holds the longest run of pulses
	function automatic int run_cnt_w(input int word_bits, input int max_idle);
		int m;
		m = (word_bits > max_idle) ? word_bits : max_idle;
		m = (m > PREACT_CLOCKS) ? m : PREACT_CLOCKS;
		return $clog2(m + 1);
	endfunction

endpackage

// File: hdl/lds_front.sv
// Front end of the LED driver serial command shifter.
// Holds the configuration registers and turns each command item into a
// pulse-run descriptor for the queue. Uses lds_pkg.
module lds_front
	import lds_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int MAX_IDLE  = MAX_IDLE_DEF,
	localparam int CNT_W    = run_cnt_w(WORD_BITS, MAX_IDLE),
	localparam int DESC_W   = WORD_BITS + 2 * CNT_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  logic [KIND_W-1:0]        kind,
	input  logic [WORD_FIELD_W-1:0]  word,
	input  logic                     latch_last,
	input  logic [IDLE_FIELD_W-1:0]  idle_count,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	output logic                     push_valid,
	input  logic                     push_full,
	output logic [DESC_W-1:0]        push_data
);

	logic        ghost_q;
	logic [6:0]  scan_q;
	logic        gray_q;
	logic        gclk_q;
	logic [5:0]  current_q;

	logic [31:0]             word_ext;
	logic [31:0]             cfg_ext;
	logic [IDLE_FIELD_W-1:0] idle_c;
	logic [WORD_BITS-1:0]    d_data;
	logic [CNT_W-1:0]        d_len;
	logic [CNT_W-1:0]        d_tail;
	logic                    known;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ghost_q   <= 1'b0;
			scan_q    <= '0;
			gray_q    <= 1'b0;
			gclk_q    <= 1'b0;
			current_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GHOST:   ghost_q   <= cfg_data[0];
				REG_SCAN:    scan_q    <= cfg_data[6:0];
				REG_GRAY:    gray_q    <= cfg_data[0];
				REG_GCLK:    gclk_q    <= cfg_data[0];
				REG_CURRENT: current_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	assign word_ext = {16'd0, word};
	assign cfg_ext  = {16'd0, ghost_q, scan_q, gray_q, gclk_q, current_q};

	always_comb begin
		if (idle_count == '0)
			idle_c = IDLE_FIELD_W'(1);
		else if (idle_count > IDLE_FIELD_W'(MAX_IDLE))
			idle_c = IDLE_FIELD_W'(MAX_IDLE);
		else
			idle_c = idle_count;
	end

	always_comb begin
		d_data = '0;
		d_len  = CNT_W'(WORD_BITS);
		d_tail = '0;
		known  = 1'b1;
		case (kind_t'(kind))
			KIND_DATA: begin
				d_data = word_ext[WORD_BITS-1:0];
				d_tail = latch_last ? CNT_W'(1) : '0;
			end
			KIND_CONFIG: begin
				d_data = cfg_ext[WORD_BITS-1:0];
				d_tail = latch_last ? CNT_W'(CFG_LATCH_BITS) : '0;
			end
			KIND_PREACT: begin
				d_len  = CNT_W'(PREACT_CLOCKS);
				d_tail = CNT_W'(PREACT_CLOCKS);
			end
			KIND_VSYNC: begin
				d_len  = CNT_W'(VSYNC_CLOCKS);
				d_tail = CNT_W'(VSYNC_CLOCKS);
			end
			KIND_SRESET: begin
				d_len  = CNT_W'(SRESET_CLOCKS);
				d_tail = CNT_W'(SRESET_CLOCKS);
			end
			KIND_IDLE: begin
				d_len  = CNT_W'(idle_c);
			end
			default: known = 1'b0;
		endcase
	end

	// unused kinds are taken and dropped
	assign cmd_stall  = push_full;
	assign push_valid = cmd_valid && !push_full && known;
	assign push_data  = {d_data, d_len, d_tail};

endmodule

// File: hdl/lds_queue.sv
// Short descriptor queue between front and back of the command shifter.
// Register-based FIFO of QUEUE_DEPTH entries. Uses lds_pkg.
module lds_queue
	import lds_pkg::*;
#(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [DATA_W-1:0] wr_data,
	output logic              full,
	input  logic              rd_en,
	output logic              rd_valid,
	output logic [DATA_W-1:0] rd_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_wr;
	logic              do_rd;

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/lds_back.sv
// Back end of the LED driver serial command shifter.
// Pulls run descriptors from the queue and shifts out one pulse per cycle,
// unless res_stall holds it, into the result register. Uses lds_pkg.
module lds_back
	import lds_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int MAX_IDLE  = MAX_IDLE_DEF,
	localparam int CNT_W    = run_cnt_w(WORD_BITS, MAX_IDLE),
	localparam int DESC_W   = WORD_BITS + 2 * CNT_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pop_valid,
	input  logic [DESC_W-1:0] pop_data,
	output logic              pop_en,
	output logic              res_valid,
	input  logic              res_stall,
	output logic              serial_bit,
	output logic              latch_enable,
	output logic              run_end
);

	logic                 active_q;
	logic [WORD_BITS-1:0] shift_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W-1:0]     tail_q;
	logic                 out_valid_q;
	logic                 serial_q;
	logic                 le_q;
	logic                 end_q;

	logic free;
	logic emit;
	logic last;

	assign free   = !out_valid_q || !res_stall;
	assign emit   = active_q && free;
	assign last   = (rem_q == CNT_W'(1));
	assign pop_en = pop_valid && (!active_q || (emit && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free)
				out_valid_q <= active_q;
			if (pop_en)
				active_q <= 1'b1;
			else if (emit && last)
				active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			serial_q <= shift_q[WORD_BITS-1];
			le_q     <= (rem_q <= tail_q);
			end_q    <= last;
		end
		if (pop_en) begin
			shift_q <= pop_data[DESC_W-1 -: WORD_BITS];
			rem_q   <= pop_data[2*CNT_W-1 -: CNT_W];
			tail_q  <= pop_data[CNT_W-1:0];
		end else if (emit) begin
			shift_q <= {shift_q[WORD_BITS-2:0], 1'b0};
			rem_q   <= rem_q - 1'b1;
		end
	end

	assign res_valid    = out_valid_q;
	assign serial_bit   = serial_q;
	assign latch_enable = le_q;
	assign run_end      = end_q;

`ifndef SYNTHESIS
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (rem_q != '0))
		else $error("active run with zero pulses left");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !end_q) |-> active_q)
		else $error("run ended before its last pulse");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last && !pop_en) |=> !active_q)
		else $error("run stayed active after its last pulse");
`endif

endmodule

// File: hdl/led_driver_serial_command_shifter_core.sv
// Rate: one result per unstalled clock. A data or config command yields
// WORD_BITS results, pre-activate 14, vertical sync 2, soft reset 10, and
// idle 1..MAX_IDLE; kinds 6 and 7 are taken and produce nothing. The back
// end's shift stage emits one pulse per cycle and loads the next command on
// the last pulse of the current one, so runs follow each other without a
// gap; a two-entry queue lets the front take new commands while a run is
// out. Top level; uses lds_pkg, lds_front, lds_queue and lds_back.
module led_driver_serial_command_shifter_core
	import lds_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int MAX_IDLE  = MAX_IDLE_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  logic [KIND_W-1:0]        kind,
	input  logic [WORD_FIELD_W-1:0]  word,
	input  logic                     latch_last,
	input  logic [IDLE_FIELD_W-1:0]  idle_count,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic                     serial_bit,
	output logic                     latch_enable,
	output logic                     run_end,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	localparam int CNT_W  = run_cnt_w(WORD_BITS, MAX_IDLE);
	localparam int DESC_W = WORD_BITS + 2 * CNT_W;

	logic              push_valid;
	logic              push_full;
	logic [DESC_W-1:0] push_data;
	logic              pop_en;
	logic              pop_valid;
	logic [DESC_W-1:0] pop_data;

	lds_front #(
		.WORD_BITS (WORD_BITS),
		.MAX_IDLE  (MAX_IDLE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.kind       (kind),
		.word       (word),
		.latch_last (latch_last),
		.idle_count (idle_count),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_full  (push_full),
		.push_data  (push_data)
	);

	lds_queue #(
		.DATA_W (DESC_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push_valid),
		.wr_data  (push_data),
		.full     (push_full),
		.rd_en    (pop_en),
		.rd_valid (pop_valid),
		.rd_data  (pop_data)
	);

	lds_back #(
		.WORD_BITS (WORD_BITS),
		.MAX_IDLE  (MAX_IDLE)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_data     (pop_data),
		.pop_en       (pop_en),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.serial_bit   (serial_bit),
		.latch_enable (latch_enable),
		.run_end      (run_end)
	);

endmodule
